/* hdl/dsm2sfb_pkg.sv */
// Package with the shared types, codes and constants of the serial frame builder.
`timescale 1ns / 1ps

package dsm2sfb_pkg;

   localparam int CHAN_INPUTS      = 6;
   localparam int NUM_CHANNELS_DEF = 6;
   localparam int CHAN_WIDTH       = 12;
   localparam int CSR_DATA_WIDTH   = 8;
   localparam int CSR_INDEX_WIDTH  = 2;

   localparam logic [7:0] HDR_LP45        = 8'h00;
   localparam logic [7:0] HDR_DSM2        = 8'h10;
   localparam logic [7:0] HDR_DSMX        = 8'h18;
   localparam logic [7:0] SEND_BIND       = 8'h80;
   localparam logic [7:0] SEND_RANGECHECK = 8'h20;

   localparam logic [1:0] MODE_LP45 = 2'd0;
   localparam logic [1:0] MODE_DSM2 = 2'd1;
   localparam logic [1:0] MODE_DSMX = 2'd2;

   localparam logic [1:0] FLAG_NONE  = 2'd0;
   localparam logic [1:0] FLAG_BIND  = 2'd1;
   localparam logic [1:0] FLAG_RANGE = 2'd2;

   localparam logic [1:0] PROTOCOL_MODE_RESET = MODE_DSMX;
   localparam logic [7:0] MODEL_ID_RESET      = 8'd0;
   localparam logic [7:0] BIND_TIMEOUT_RESET  = 8'd255;

   localparam logic signed [15:0] SCALE_NUM = 16'sd13;
   localparam logic signed [11:0] PULSE_MID = 12'sd512;
   localparam logic signed [11:0] PULSE_MAX = 12'sd1023;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PROTOCOL_MODE = 2'd0,
      CSR_MODEL_ID      = 2'd1,
      CSR_BIND_TIMEOUT  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                              write_en;
      logic [CSR_INDEX_WIDTH-1:0]        index;
      logic [CSR_DATA_WIDTH-1:0]         wdata;
   } csr_wr_type;

   typedef struct packed {
      logic                         tx_busy;
      logic                         bind_switch;
      logic [1:0]                   module_request;
      logic signed [CHAN_WIDTH-1:0] chan0;
      logic signed [CHAN_WIDTH-1:0] chan1;
      logic signed [CHAN_WIDTH-1:0] chan2;
      logic signed [CHAN_WIDTH-1:0] chan3;
      logic signed [CHAN_WIDTH-1:0] chan4;
      logic signed [CHAN_WIDTH-1:0] chan5;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_last;
      logic [1:0] module_flag_out;
   } rsp_type;

   typedef struct packed {
      logic [7:0] header;
      logic [7:0] model_id;
      logic [1:0] flag;
   } hdr_type;

endpackage

/* hdl/dsm2sfb_hdr.sv */
// Configuration registers, bind window countdown and header byte logic.
`timescale 1ns / 1ps

module dsm2sfb_hdr (
   input  logic                    clock,
   input  logic                    reset,
   input  dsm2sfb_pkg::csr_wr_type csr_wr,
   input  logic                    advance,
   input  logic                    bind_switch,
   input  logic [1:0]              module_request,
   output dsm2sfb_pkg::hdr_type    hdr
);

   logic [1:0] protocol_mode_ff, protocol_mode_in;
   logic [7:0] model_id_ff, model_id_in;
   logic [7:0] countdown_ff, countdown_in;
   logic [7:0] base;
   logic [1:0] req_flag;

   always_comb begin
      protocol_mode_in = protocol_mode_ff;
      model_id_in      = model_id_ff;
      countdown_in     = countdown_ff;
      if (advance && countdown_ff != 8'd0) begin
         countdown_in = countdown_ff - 8'd1;
      end
      if (csr_wr.write_en) begin
         case (dsm2sfb_pkg::csr_index_type'(csr_wr.index))
            dsm2sfb_pkg::CSR_PROTOCOL_MODE: protocol_mode_in = csr_wr.wdata[1:0];
            dsm2sfb_pkg::CSR_MODEL_ID:      model_id_in      = csr_wr.wdata;
            // A new timeout also restarts the bind window.
            dsm2sfb_pkg::CSR_BIND_TIMEOUT:  countdown_in     = csr_wr.wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         protocol_mode_ff <= dsm2sfb_pkg::PROTOCOL_MODE_RESET;
         model_id_ff      <= dsm2sfb_pkg::MODEL_ID_RESET;
         countdown_ff     <= dsm2sfb_pkg::BIND_TIMEOUT_RESET;
      end else begin
         protocol_mode_ff <= protocol_mode_in;
         model_id_ff      <= model_id_in;
         countdown_ff     <= countdown_in;
      end
   end

   always_comb begin
      case (protocol_mode_ff)
         dsm2sfb_pkg::MODE_LP45: base = dsm2sfb_pkg::HDR_LP45;
         dsm2sfb_pkg::MODE_DSM2: base = dsm2sfb_pkg::HDR_DSM2;
         default:                base = dsm2sfb_pkg::HDR_DSMX;
      endcase

      // The unused request code behaves as no request.
      req_flag = (module_request == dsm2sfb_pkg::FLAG_BIND ||
                  module_request == dsm2sfb_pkg::FLAG_RANGE) ? module_request
                                                              : dsm2sfb_pkg::FLAG_NONE;

      hdr.model_id = model_id_ff;
      hdr.header   = base;
      hdr.flag     = dsm2sfb_pkg::FLAG_NONE;
      if (countdown_ff != 8'd0) begin
         if (bind_switch) begin
            hdr.flag   = dsm2sfb_pkg::FLAG_BIND;
            hdr.header = base | dsm2sfb_pkg::SEND_BIND;
         end else begin
            hdr.flag = req_flag;
         end
      end else if (req_flag == dsm2sfb_pkg::FLAG_RANGE) begin
         hdr.flag   = dsm2sfb_pkg::FLAG_RANGE;
         hdr.header = base | dsm2sfb_pkg::SEND_RANGECHECK;
      end
   end

endmodule

/* hdl/dsm2sfb_chan.sv */
// Scales one channel value to a 10-bit pulse and forms its two frame bytes.
`timescale 1ns / 1ps

module dsm2sfb_chan #(
   parameter int CHAN_INDEX = 0
) (
   input  logic signed [dsm2sfb_pkg::CHAN_WIDTH-1:0] chan,
   output logic [7:0]                                byte_hi,
   output logic [7:0]                                byte_lo
);

   logic signed [15:0] chan_ext;
   logic signed [15:0] prod;
   logic signed [10:0] quot;
   logic signed [11:0] offs;
   logic [9:0]         pulse;

   always_comb begin
      chan_ext = {{(16 - dsm2sfb_pkg::CHAN_WIDTH){chan[dsm2sfb_pkg::CHAN_WIDTH-1]}}, chan};
      prod     = chan_ext * dsm2sfb_pkg::SCALE_NUM;
      // Arithmetic shift right by five is the floor of the division by 32.
      quot     = prod[15:5];
      offs     = {quot[10], quot} + dsm2sfb_pkg::PULSE_MID;
      if (offs < 12'sd0) begin
         pulse = 10'd0;
      end else if (offs > dsm2sfb_pkg::PULSE_MAX) begin
         pulse = dsm2sfb_pkg::PULSE_MAX[9:0];
      end else begin
         pulse = offs[9:0];
      end
      byte_hi = {6'(CHAN_INDEX), pulse[9:8]};
      byte_lo = pulse[7:0];
   end

endmodule

/* hdl/dsm2sfb_emit.sv */
// Frame buffer that sends a loaded frame one byte per transaction.
`timescale 1ns / 1ps

module dsm2sfb_emit #(
   parameter int FRAME_BYTES = 14
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic [7:0]           load_bytes [FRAME_BYTES],
   input  logic [1:0]           load_flag,
   output logic                 load_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output dsm2sfb_pkg::rsp_type rsp_data
);

   localparam int CNT_W = $clog2(FRAME_BYTES + 1);

   logic [7:0]       frame_ff [FRAME_BYTES];
   logic [7:0]       frame_in [FRAME_BYTES];
   logic [CNT_W-1:0] count_ff, count_in;
   logic [1:0]       flag_ff, flag_in;
   logic             take;

   assign take       = rsp_valid && !rsp_stall;
   assign rsp_valid  = count_ff != '0;
   // A new frame can enter as the last byte of the current one leaves.
   assign load_ready = (count_ff == '0) || (count_ff == CNT_W'(1) && !rsp_stall);

   assign rsp_data.frame_byte      = frame_ff[0];
   assign rsp_data.frame_last      = count_ff == CNT_W'(1);
   assign rsp_data.module_flag_out = flag_ff;

   always_comb begin
      frame_in = frame_ff;
      count_in = count_ff;
      flag_in  = flag_ff;
      if (load) begin
         frame_in = load_bytes;
         count_in = CNT_W'(FRAME_BYTES);
         flag_in  = load_flag;
      end else if (take) begin
         for (int i = 0; i < FRAME_BYTES - 1; i++) begin
            frame_in[i] = frame_ff[i+1];
         end
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
      flag_ff  <= flag_in;
   end

endmodule

/* hdl/dsm2_serial_frame_builder_core.sv */
// Top level of the serial radio-module frame builder.
`timescale 1ns / 1ps

// Usage:
// A request transaction on req_* carries the busy flag, the bind switch, the
// requested module flag and six signed channel values. A request that finds
// the transmitter busy is accepted and dropped without any effect. Any other
// request produces one frame of 2 + 2 * channels bytes (14 by default), sent
// as one rsp_* transaction per byte: header, model id, then a high and a low
// byte per channel. frame_last marks the final byte; every byte of a frame
// carries the same updated module flag.
// Requests are registered on entry; the frame is formed combinationally from
// the input register and loaded into the byte buffer when it has room. The
// byte buffer sends one byte per cycle while rsp_stall is low and takes the
// next frame as the last byte leaves, so frames follow without a gap, limited
// by the single byte-wide result port.
// A stall on rsp_* holds the current byte; the input register then fills and
// req_stall rises until the buffer frees. The csr_* port writes the protocol
// mode, model id and bind timeout; writing the timeout restarts the bind
// window. Reset empties both stages and restores the register defaults.
module dsm2_serial_frame_builder_core #(
   parameter int NUM_CHANNELS = dsm2sfb_pkg::NUM_CHANNELS_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  dsm2sfb_pkg::req_type                       req_data,
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output dsm2sfb_pkg::rsp_type                       rsp_data,
   input  logic                                       csr_write_en,
   input  logic [dsm2sfb_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [dsm2sfb_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);

   localparam int NCH = (NUM_CHANNELS > dsm2sfb_pkg::CHAN_INPUTS) ?
                        dsm2sfb_pkg::CHAN_INPUTS : NUM_CHANNELS;
   localparam int FRAME_BYTES = 2 + 2 * NCH;

   logic                    in_valid_ff, in_valid_in;
   dsm2sfb_pkg::req_type    in_data_ff;
   logic                    consume;
   logic                    load;
   logic                    load_ready;
   dsm2sfb_pkg::csr_wr_type csr_wr;
   dsm2sfb_pkg::hdr_type    hdr;
   logic signed [dsm2sfb_pkg::CHAN_WIDTH-1:0] chans [dsm2sfb_pkg::CHAN_INPUTS];
   logic [7:0]              frame_bytes [FRAME_BYTES];

   assign consume   = in_valid_ff && (in_data_ff.tx_busy || load_ready);
   assign load      = consume && !in_data_ff.tx_busy;
   assign req_stall = in_valid_ff && !consume;

   assign in_valid_in = (req_valid && !req_stall) || (in_valid_ff && !consume);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   assign csr_wr.write_en = csr_write_en;
   assign csr_wr.index    = csr_index;
   assign csr_wr.wdata    = csr_wdata;

   dsm2sfb_hdr u_hdr (
      .clock          (clock),
      .reset          (reset),
      .csr_wr         (csr_wr),
      .advance        (load),
      .bind_switch    (in_data_ff.bind_switch),
      .module_request (in_data_ff.module_request),
      .hdr            (hdr)
   );

   assign chans[0] = in_data_ff.chan0;
   assign chans[1] = in_data_ff.chan1;
   assign chans[2] = in_data_ff.chan2;
   assign chans[3] = in_data_ff.chan3;
   assign chans[4] = in_data_ff.chan4;
   assign chans[5] = in_data_ff.chan5;

   assign frame_bytes[0] = hdr.header;
   assign frame_bytes[1] = hdr.model_id;

   for (genvar i = 0; i < NCH; i++) begin : g_chan
      dsm2sfb_chan #(
         .CHAN_INDEX (i)
      ) u_chan (
         .chan    (chans[i]),
         .byte_hi (frame_bytes[2 + 2 * i]),
         .byte_lo (frame_bytes[3 + 2 * i])
      );
   end

   dsm2sfb_emit #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .load_bytes (frame_bytes),
      .load_flag  (hdr.flag),
      .load_ready (load_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

/* hdl/dsm2sfb_checker.sv */
// Port-level checks for the serial frame builder, bound to its top level.
`timescale 1ns / 1ps

module dsm2sfb_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_valid,
   input logic                                    req_stall,
   input dsm2sfb_pkg::req_type                    req_data,
   input logic                                    rsp_valid,
   input logic                                    rsp_stall,
   input dsm2sfb_pkg::rsp_type                    rsp_data,
   input logic                                    csr_write_en,
   input logic [dsm2sfb_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input logic [dsm2sfb_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   // A stalled byte stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result transaction changed");

   // Reset leaves no byte on offer.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // Bytes of one frame follow each other without a gap.
   a_frame_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.frame_last |=> rsp_valid)
      else $error("gap inside a frame");

   // The module flag is the same on every byte of a frame.
   a_flag_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.frame_last |=>
         rsp_data.module_flag_out == $past(rsp_data.module_flag_out))
      else $error("module flag changed inside a frame");

   // The unused flag code never appears.
   a_flag_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.module_flag_out != 2'd3)
      else $error("invalid module flag code");

endmodule

bind dsm2_serial_frame_builder_core dsm2sfb_checker u_checker (.*);
